[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while out of reset
`define CHK_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// property checked on every edge, reset included
`define CHK_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/rsppr_pkg.sv]
package rsppr_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_kind;
    typedef logic [2:0] t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // framing characters
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_HASH   = 8'h23;
    localparam t_byte CH_ESCAPE = 8'h7d;
    localparam t_byte CH_NUL    = 8'h00;
    localparam t_byte ESC_XOR   = 8'h20;
    localparam t_byte CH_ACK    = 8'h2b;
    localparam t_byte CH_NAK    = 8'h2d;

    // result kinds
    localparam t_kind K_DATA  = 3'd0;
    localparam t_kind K_GOOD  = 3'd1;
    localparam t_kind K_NOACK = 3'd2;
    localparam t_kind K_BAD   = 3'd3;
    localparam t_kind K_ABORT = 3'd4;

    // receive phases
    localparam t_phase PH_HUNT = 3'd0;
    localparam t_phase PH_BODY = 3'd1;
    localparam t_phase PH_ESC  = 3'd2;
    localparam t_phase PH_DIG1 = 3'd3;
    localparam t_phase PH_DIG2 = 3'd4;

    // ascii hex digit decode, plain digits only
    function automatic t_hex hex_decode(input t_byte c);
        t_hex  h;
        t_byte d;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d     = c - 8'h30;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d     = c - 8'h57;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d     = c - 8'h37;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end
        return h;
    endfunction

endpackage

[design/rsp_packet_receiver_core.sv]
// throughput: one byte per cycle while the output is not stalled; bytes with no result never wait on the output
// the input register and the result register are parted by one level of decode logic
// reset: synchronous active low; clears phase, checksum, digit state, no_ack and valids
module rsp_packet_receiver_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rsppr_pkg::t_byte     i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rsppr_pkg::t_kind     o_kind,
    output rsppr_pkg::t_byte     o_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_no_ack
);
    import rsppr_pkg::*;

    logic   r_no_ack;
    logic   r_in_valid;
    t_byte  r_in_byte;
    t_phase r_phase, n_phase;
    t_byte  r_sum, n_sum;
    logic [3:0] r_high, n_high;
    logic   r_high_ok, n_high_ok;
    logic   r_out_valid;
    t_kind  r_out_kind;
    t_byte  r_out_value;

    logic   emit;
    t_kind  res_kind;
    t_byte  res_value;
    logic   in_frame;
    logic   out_free;
    logic   advance;
    t_hex   hex;

    // config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_ack <= 1'b0;
        end else if (i_cfg_valid) begin
            r_no_ack <= i_cfg_no_ack;
        end
    end

    // decode of the held byte against the frame state
    assign hex      = hex_decode(r_in_byte);
    assign in_frame = (r_phase == PH_BODY) || (r_phase == PH_ESC) ||
                      (r_phase == PH_DIG1) || (r_phase == PH_DIG2);

    always_comb begin
        n_phase   = r_phase;
        n_sum     = r_sum;
        n_high    = r_high;
        n_high_ok = r_high_ok;
        emit      = 1'b0;
        res_kind  = K_DATA;
        res_value = r_sum;
        if (!in_frame) begin
            // hunt for start, unused codes too
            n_phase = PH_HUNT;
            if (r_in_byte == CH_DOLLAR) begin
                n_phase = PH_BODY;
                n_sum   = 8'd0;
            end
        end else if (r_in_byte == CH_DOLLAR) begin
            // abort and restart
            n_phase  = PH_BODY;
            n_sum    = 8'd0;
            emit     = 1'b1;
            res_kind = K_ABORT;
        end else begin
            case (r_phase)
                PH_BODY: begin
                    if (r_in_byte == CH_NUL || r_in_byte == CH_HASH) begin
                        n_phase = PH_DIG1;
                    end else begin
                        n_sum = r_sum + r_in_byte;
                        if (r_in_byte == CH_ESCAPE) begin
                            n_phase = PH_ESC;
                        end else begin
                            emit      = 1'b1;
                            res_kind  = K_DATA;
                            res_value = r_in_byte;
                        end
                    end
                end
                PH_ESC: begin
                    if (r_in_byte == CH_HASH) begin
                        n_phase = PH_DIG1;
                    end else begin
                        n_sum     = r_sum + r_in_byte;
                        n_phase   = PH_BODY;
                        emit      = 1'b1;
                        res_kind  = K_DATA;
                        res_value = r_in_byte ^ ESC_XOR;
                    end
                end
                PH_DIG1: begin
                    n_high_ok = hex.ok;
                    n_high    = hex.val;
                    n_phase   = PH_DIG2;
                end
                default: begin
                    // second digit: verdict
                    emit = 1'b1;
                    if (r_no_ack) begin
                        n_phase  = PH_HUNT;
                        res_kind = K_NOACK;
                    end else if (r_high_ok && hex.ok && {r_high, hex.val} == r_sum) begin
                        n_phase  = PH_HUNT;
                        res_kind = K_GOOD;
                    end else begin
                        n_phase  = PH_BODY;
                        n_sum    = 8'd0;
                        res_kind = K_BAD;
                    end
                end
            endcase
        end
    end

    // handshake between the two registers
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (out_free || !emit);
    assign o_stall  = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // frame state update on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_sum     <= 8'd0;
            r_high    <= 4'd0;
            r_high_ok <= 1'b0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_sum     <= n_sum;
            r_high    <= n_high;
            r_high_ok <= n_high_ok;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_kind  <= res_kind;
            r_out_value <= res_value;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_value = r_out_value;

endmodule

[design/rsppr_checker.sv]
`include "assert_macros.svh"

module rsppr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input rsppr_pkg::t_kind o_kind
);
    import rsppr_pkg::*;

    // a stalled result stays offered
    `CHK_RUN(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "result dropped while stalled")

    // only known result kinds leave the block
    `CHK_RUN(a_kind_range, i_clk, i_rst_n, o_valid |-> o_kind <= K_ABORT, "illegal result kind")

    // input only backs up when the output side is stalled
    `CHK_RUN(a_stall_cause, i_clk, i_rst_n, !i_stall |-> !o_stall, "input stalled with output free")

    // nothing is offered right after reset
    `CHK_ALL(a_reset_quiet, i_clk, ($past(i_rst_n) == 1'b0) |-> !o_valid, "result after reset")

endmodule

bind rsp_packet_receiver_core rsppr_checker u_rsppr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_kind  (o_kind)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import rsppr_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 80;

    typedef struct packed {
        logic  has;
        t_kind kind;
        t_byte value;
    } rx_result_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        t_byte rx;
        logic  typed;
        logic  has;
        t_kind kind;
        t_byte value;
    } dir_row_t;

    localparam int DIR_ROWS = 27;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{CH_NUL,    1'b1, 1'b0, K_DATA,  8'h00},  // dropped while hunting
        '{8'hff,     1'b1, 1'b0, K_DATA,  8'h00},
        '{CH_HASH,   1'b1, 1'b0, K_DATA,  8'h00},
        '{CH_DOLLAR, 1'b1, 1'b0, K_DATA,  8'h00},
        '{8'hff,     1'b1, 1'b1, K_DATA,  8'hff},
        '{CH_ESCAPE, 1'b0, 1'b0, K_DATA,  8'h00},
        '{CH_NUL,    1'b1, 1'b1, K_DATA,  8'h20},  // escaped zero stays payload
        '{CH_ESCAPE, 1'b0, 1'b0, K_DATA,  8'h00},
        '{CH_HASH,   1'b0, 1'b0, K_DATA,  8'h00},  // hash right after escape
        '{"f",       1'b0, 1'b0, K_DATA,  8'h00},
        '{"9",       1'b0, 1'b0, K_DATA,  8'h00},
        '{CH_DOLLAR, 1'b0, 1'b0, K_DATA,  8'h00},
        '{"A",       1'b1, 1'b1, K_DATA,  8'h41},
        '{CH_NUL,    1'b0, 1'b0, K_DATA,  8'h00},  // zero byte ends payload
        '{"4",       1'b0, 1'b0, K_DATA,  8'h00},
        '{"G",       1'b1, 1'b1, K_BAD,   8'h41},  // non-hex low digit
        '{CH_HASH,   1'b0, 1'b0, K_DATA,  8'h00},
        '{CH_DOLLAR, 1'b1, 1'b1, K_ABORT, 8'h00},  // dollar in first digit slot
        '{CH_ESCAPE, 1'b0, 1'b0, K_DATA,  8'h00},
        '{CH_DOLLAR, 1'b1, 1'b1, K_ABORT, 8'h7d},  // dollar after escape
        '{"7",       1'b0, 1'b0, K_DATA,  8'h00},
        '{CH_HASH,   1'b0, 1'b0, K_DATA,  8'h00},
        '{"3",       1'b0, 1'b0, K_DATA,  8'h00},
        '{CH_DOLLAR, 1'b1, 1'b1, K_ABORT, 8'h37},  // dollar in second digit slot
        '{CH_HASH,   1'b0, 1'b0, K_DATA,  8'h00},
        '{"0",       1'b0, 1'b0, K_DATA,  8'h00},
        '{"0",       1'b0, 1'b0, K_DATA,  8'h00}
    };

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_byte i_rx_byte;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_kind o_kind;
    t_byte o_value;
    logic  i_cfg_valid;
    logic  o_cfg_ready;
    logic  i_cfg_no_ack;

    // frame tracker state
    t_phase     frm_phase = PH_HUNT;
    t_byte      frm_sum   = '0;
    logic [3:0] frm_hi    = '0;
    logic       frm_hi_ok = 1'b0;
    logic       mode_no_ack = 1'b0;

    rx_result_t pending_results [$];
    int         items_sent = 0;
    int         fail_cnt   = 0;
    int         kind_seen [5] = '{default: 0};
    int         stall_hold = 0;
    bit         quiet      = 1'b0;

    rsp_packet_receiver_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_no_ack(i_cfg_no_ack)
    );

    always #2 i_clk = ~i_clk;

    // plain hex digit decode: {ok, nibble}
    function automatic logic [4:0] hex_nibble(input t_byte c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'b0;
    endfunction

    function automatic t_byte hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return t_byte'("0") + t_byte'(n);
        return (upper ? t_byte'("A") : t_byte'("a")) + t_byte'(n) - 8'd10;
    endfunction

    // advance the frame tracker by one byte and return what it should report
    function automatic rx_result_t rx_frame_step(input t_byte c);
        rx_result_t r;
        t_byte      s;
        logic [4:0] lo;
        r = '0;
        s = frm_sum;
        if (frm_phase == PH_HUNT || frm_phase > PH_DIG2) begin
            frm_phase = PH_HUNT;
            if (c == CH_DOLLAR) begin
                frm_phase = PH_BODY;
                frm_sum   = '0;
            end
        end else if (c == CH_DOLLAR) begin
            r         = '{1'b1, K_ABORT, s};
            frm_phase = PH_BODY;
            frm_sum   = '0;
        end else begin
            case (frm_phase)
                PH_BODY: begin
                    if (c == CH_NUL || c == CH_HASH) begin
                        frm_phase = PH_DIG1;
                    end else begin
                        frm_sum = s + c;
                        if (c == CH_ESCAPE) frm_phase = PH_ESC;
                        else r = '{1'b1, K_DATA, c};
                    end
                end
                PH_ESC: begin
                    if (c == CH_HASH) begin
                        frm_phase = PH_DIG1;
                    end else begin
                        frm_sum   = s + c;
                        frm_phase = PH_BODY;
                        r         = '{1'b1, K_DATA, c ^ ESC_XOR};
                    end
                end
                PH_DIG1: begin
                    {frm_hi_ok, frm_hi} = hex_nibble(c);
                    frm_phase = PH_DIG2;
                end
                default: begin
                    lo = hex_nibble(c);
                    if (mode_no_ack) begin
                        r         = '{1'b1, K_NOACK, s};
                        frm_phase = PH_HUNT;
                    end else if (frm_hi_ok && lo[4] && {frm_hi, lo[3:0]} == s) begin
                        r         = '{1'b1, K_GOOD, s};
                        frm_phase = PH_HUNT;
                    end else begin
                        r         = '{1'b1, K_BAD, s};
                        frm_phase = PH_BODY;
                        frm_sum   = '0;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // offer one byte, wait for the transfer, then track it
    task automatic offer_byte(input t_byte b, output rx_result_t r);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        r = rx_frame_step(b);
        items_sent++;
    endtask

    task automatic send_byte(input t_byte b);
        rx_result_t r;
        offer_byte(b, r);
        if (r.has) pending_results.push_back(r);
    endtask

    // stop sending until every outstanding result is back and the pipe is empty
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_no_ack(input logic v);
        wait_drained();
        i_cfg_valid  <= 1'b1;
        i_cfg_no_ack <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_no_ack = v;
    endtask

    // one frame up to and including its first checksum digit
    task automatic open_digits(input t_byte payload, input t_byte dig);
        send_byte(CH_DOLLAR);
        send_byte(payload);
        send_byte(CH_HASH);
        send_byte(dig);
    endtask

    // mostly well-formed frames with random content, plus noise and breakage
    task automatic send_frame();
        t_byte b;
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 3)) send_byte(t_byte'($urandom_range(0, 255)));
        send_byte(CH_DOLLAR);
        repeat ($urandom_range(0, 10)) begin
            if ($urandom_range(0, 99) < 15) begin
                send_byte(CH_ESCAPE);
                send_byte(t_byte'($urandom_range(0, 255)));
            end else begin
                b = t_byte'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 95)
                    while (b == CH_DOLLAR || b == CH_HASH || b == CH_NUL || b == CH_ESCAPE)
                        b = t_byte'($urandom_range(0, 255));
                send_byte(b);
            end
        end
        if ($urandom_range(0, 99) < 5) send_byte(CH_DOLLAR);
        send_byte($urandom_range(0, 99) < 80 ? CH_HASH : CH_NUL);
        if ($urandom_range(0, 99) < 85) begin
            send_byte(hex_char(frm_sum[7:4], bit'($urandom_range(0, 1))));
            send_byte(hex_char(frm_sum[3:0], bit'($urandom_range(0, 1))));
        end else begin
            repeat (2) begin
                if ($urandom_range(0, 1))
                    send_byte(hex_char(4'($urandom_range(0, 15)), bit'($urandom_range(0, 1))));
                else
                    send_byte(t_byte'($urandom_range(0, 255)));
            end
        end
    endtask

    // output side stall, with a single long hold-off
    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            i_stall <= 1'b1;
            stall_hold--;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < 10);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        rx_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d value %02h", o_kind, o_value);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, o_kind);
                    fail_cnt++;
                end
                if (o_value !== want.value) begin
                    $error("value mismatch: expected %02h, actual %02h", want.value, o_value);
                    fail_cnt++;
                end
            end
            if (o_kind <= K_ABORT) kind_seen[o_kind]++;
        end
    end

    // main sequence
    initial begin
        rx_result_t got;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_rx_byte    <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_no_ack <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_no_ack(1'b0);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            offer_byte(DIR_TAB[i].rx, got);
            if (DIR_TAB[i].typed) begin
                if (DIR_TAB[i].has)
                    pending_results.push_back('{1'b1, DIR_TAB[i].kind, DIR_TAB[i].value});
            end else if (got.has) begin
                pending_results.push_back(got);
            end
        end

        // checked mode, starting under a long output hold-off
        stall_hold = HOLD_CYCLES;
        while (items_sent < 330) send_frame();

        // switch to no-ack between the two checksum digits
        open_digits("b", "x");
        write_no_ack(1'b1);
        send_byte("y");
        while (items_sent < 530) send_frame();

        // and back again mid-frame
        open_digits("a", "1");
        write_no_ack(1'b0);
        send_byte("2");

        // idle-free stretch, then random idling again
        quiet = 1'b1;
        while (items_sent < 650) send_frame();
        quiet = 1'b0;
        while (items_sent < 830) send_frame();

        wait_drained();
        $display("%0d bytes: %0d payload, %0d good, %0d no-ack, %0d bad checksum, %0d aborted",
                 items_sent, kind_seen[K_DATA], kind_seen[K_GOOD], kind_seen[K_NOACK],
                 kind_seen[K_BAD], kind_seen[K_ABORT]);
        $display("no_ack switched mid-frame both ways; long hold-off and idle-free run covered");
        if (fail_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // run limit
    initial begin
        #(2_000_000);
        $display("tb_top failed");
        $finish;
    end

endmodule
